/* rtl/usp_pkg.sv */
// Shared constants for the ultrasonic presence arming block.
package usp_pkg;

  // Item kinds
  localparam logic [1:0] KindEcho = 2'd0;
  localparam logic [1:0] KindTick = 2'd1;
  localparam logic [1:0] KindMic  = 2'd2;

  // Configuration register indices
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgAbsencePeriod = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgHitBase       = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgNearLimit     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFarLimit      = 3'd3;

  // Register reset values
  localparam logic [15:0] AbsencePeriodRst = 16'd500;
  localparam logic [7:0]  HitBaseRst       = 8'd200;
  localparam logic [9:0]  NearLimitRst     = 10'd40;
  localparam logic [9:0]  FarLimitRst      = 10'd120;

  // Echo time to distance: cm = count * 17150 / clock rate
  localparam int unsigned ClkHzDefault = 16000000;
  localparam int unsigned SoundNum     = 17150;
  localparam longint unsigned MaxEchoProd = 64'd65535 * 64'd17150;
  localparam int unsigned ProdW        = $clog2(MaxEchoProd + 1);

  // Hit counter limits (10 bit two's complement)
  localparam logic signed [9:0] HitMax = 10'sd511;
  localparam logic signed [9:0] HitMin = -10'sd512;

endpackage

/* rtl/usp_req_mul.sv */
// Bit-serial hit_base x pot multiplier with a final divide by 255.
module usp_req_mul (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [7:0] base_i,
  input  logic [7:0] pot_i,
  output logic       busy_o,
  output logic [7:0] req_o
);
  logic        busy_q;
  logic [2:0]  cnt_q;
  logic [15:0] acc_q, acc_d;
  logic [15:0] mcand_q;
  logic [7:0]  mplier_q;
  logic [7:0]  req_q;
  logic [16:0] sum255;

  // one multiplier bit per cycle
  assign acc_d  = mplier_q[0] ? acc_q + mcand_q : acc_q;
  // exact x/255 for x up to 255*255: (x + (x>>8) + 1) >> 8
  assign sum255 = {1'b0, acc_d} + 17'(acc_d[15:8]) + 17'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 3'd1;
      if (cnt_q == 3'd7) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= {8'd0, base_i};
      mplier_q <= pot_i;
    end else if (busy_q) begin
      acc_q    <= acc_d;
      mcand_q  <= {mcand_q[14:0], 1'b0};
      mplier_q <= {1'b0, mplier_q[7:1]};
      if (cnt_q == 3'd7) begin
        req_q <= sum255[15:8];
      end
    end
  end

  assign busy_o = busy_q;
  assign req_o  = req_q;
endmodule

/* rtl/usp_dist_div.sv */
// Restoring divider: distance = count * 17150 / CLK_HZ, one quotient bit per cycle.
module usp_dist_div #(
  parameter int unsigned CLK_HZ = usp_pkg::ClkHzDefault,
  parameter int unsigned DIST_W = 11
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [15:0]       count_i,
  output logic              busy_o,
  output logic [DIST_W-1:0] dist_o
);
  import usp_pkg::*;

  localparam int unsigned CntW = (DIST_W > 1) ? $clog2(DIST_W) : 1;
  localparam logic [ProdW-1:0] DvsInit = ProdW'(64'(CLK_HZ) << (DIST_W - 1));
  localparam logic [CntW-1:0]  CntInit = CntW'(DIST_W - 1);

  logic              busy_q;
  logic [CntW-1:0]   cnt_q;
  logic [ProdW-1:0]  rem_q, dvs_q, prod;
  logic [DIST_W-1:0] quo_q;
  logic              ge;

  assign prod = ProdW'({{(ProdW-16){1'b0}}, count_i} * ProdW'(SoundNum));
  assign ge   = (rem_q >= dvs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CntInit;
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end else begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= prod;
      dvs_q <= DvsInit;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? rem_q - dvs_q : rem_q;
      dvs_q <= {1'b0, dvs_q[ProdW-1:1]};
      quo_q <= DIST_W'({quo_q, ge});
    end
  end

  assign busy_o = busy_q;
  assign dist_o = quo_q;
endmodule

/* rtl/ultrasonic_presence_arming.sv */
// Ultrasonic presence arming: top level, presence state and beat handshakes.
// An echo beat passes through the 8-bit serial multiply and the DistW-bit serial divide,
//   which run side by side, then check and commit; other kinds go straight to commit.
// The next beat can be taken in the cycle after commit; a result still waiting in the
//   output register holds the next one in ST_DONE.
// Reset: asynchronous, active low; registers return to defaults, presence state and out_valid clear.
module ultrasonic_presence_arming #(
  parameter int unsigned CLK_HZ = usp_pkg::ClkHzDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input item channel
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [1:0]                  kind_i,
  input  logic [15:0]                 echo_count_i,
  input  logic                        echo_timeout_i,
  input  logic [7:0]                  pot_level_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        present_now_o,
  output logic                        armed_now_o,
  output logic                        echo_in_window_o,
  output logic                        arrived_o,
  output logic                        departed_o,
  output logic                        fire_action_o,
  // configuration write channel
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [usp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]                 cfg_data_i
);
  import usp_pkg::*;

  // quotient width follows from the largest valid echo and the clock rate
  localparam longint unsigned DistMax = (64'd65534 * 64'd17150) / CLK_HZ;
  localparam int unsigned DistW = $clog2(DistMax + 1);
  localparam int unsigned CmpW  = (DistW > 10) ? DistW : 10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_DONE
  } state_e;

  state_e state_q;

  // configuration registers
  logic [15:0] period_q;
  logic [7:0]  hit_base_q;
  logic [9:0]  near_q, far_q;

  // presence state
  logic [15:0]       tick_q, tick_d;
  logic signed [9:0] hit_q, hit_d;
  logic [7:0]        req_q, req_d;
  logic              present_q, present_d;
  logic              armed_q, armed_d;
  logic              window_q, window_d;
  logic              arr_d, dep_d, fire_d;

  // latched input beat
  logic [1:0]  kind_q;
  logic [15:0] count_q;
  logic        timeout_q;

  // output register
  logic out_valid_q;
  logic present_o_q, armed_o_q, window_o_q, arr_o_q, dep_o_q, fire_o_q;

  // serial units
  logic             in_acc;
  logic             mul_busy, div_busy;
  logic [7:0]       mul_req;
  logic [DistW-1:0] dist_cm;
  logic             out_free;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  // both units start on every beat; only echo beats use their answers
  usp_req_mul u_req_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .base_i  (hit_base_q),
    .pot_i   (pot_level_i),
    .busy_o  (mul_busy),
    .req_o   (mul_req)
  );

  usp_dist_div #(
    .CLK_HZ (CLK_HZ),
    .DIST_W (DistW)
  ) u_dist_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_acc),
    .count_i (echo_count_i),
    .busy_o  (div_busy),
    .dist_o  (dist_cm)
  );

  // next presence state for the beat in hand
  logic              timeout, in_win;
  logic [CmpW-1:0]   dist_x, near_x, far_x;
  logic [15:0]       tick_inc;
  logic signed [16:0] hit_x100;

  assign dist_x   = CmpW'(dist_cm);
  assign near_x   = CmpW'(near_q);
  assign far_x    = CmpW'(far_q);
  assign timeout  = timeout_q || (count_q == 16'hFFFF);
  assign in_win   = (dist_x < far_x) && (dist_x > near_x);
  assign tick_inc = tick_q + 16'd1;
  assign hit_x100 = 17'(hit_q) * 17'sd100;

  always_comb begin
    tick_d    = tick_q;
    hit_d     = hit_q;
    req_d     = req_q;
    present_d = present_q;
    armed_d   = armed_q;
    window_d  = window_q;
    arr_d     = 1'b0;
    dep_d     = 1'b0;
    fire_d    = 1'b0;
    case (kind_q)
      KindEcho: begin
        req_d = mul_req;
        if (timeout || !in_win) begin
          window_d = 1'b0;
          hit_d    = '0;
        end else begin
          window_d = 1'b1;
          if (!present_q) begin
            if (hit_q < HitMax) begin
              hit_d = hit_q + 10'sd1;
            end
            // compare the count before the increment with the new requirement
            if (hit_q >= $signed({2'b00, mul_req})) begin
              armed_d   = 1'b1;
              present_d = 1'b1;
              tick_d    = '0;
              arr_d     = 1'b1;
            end
          end
        end
      end
      KindTick: begin
        tick_d = tick_inc;
        if (tick_inc >= period_q) begin
          tick_d = '0;
          if (present_q) begin
            if (hit_q > HitMin) begin
              hit_d = hit_q - 10'sd1;
            end
            if (hit_x100 < $signed({9'd0, req_q})) begin
              armed_d   = 1'b0;
              present_d = 1'b0;
              dep_d     = 1'b1;
            end
          end
        end
      end
      KindMic: begin
        fire_d = armed_q;
      end
      default: begin
      end
    endcase
  end

  // sequencer and state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tick_q      <= '0;
      hit_q       <= '0;
      req_q       <= '0;
      present_q   <= 1'b0;
      armed_q     <= 1'b0;
      window_q    <= 1'b0;
      out_valid_q <= 1'b0;
      period_q    <= AbsencePeriodRst;
      hit_base_q  <= HitBaseRst;
      near_q      <= NearLimitRst;
      far_q       <= FarLimitRst;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgAbsencePeriod: period_q   <= cfg_data_i;
          CfgHitBase:       hit_base_q <= cfg_data_i[7:0];
          CfgNearLimit:     near_q     <= cfg_data_i[9:0];
          CfgFarLimit:      far_q      <= cfg_data_i[9:0];
          default: begin
          end
        endcase
      end

      // a new result replaces the one leaving on the same edge
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            state_q <= (kind_i == KindEcho) ? ST_BUSY : ST_DONE;
          end
        end
        ST_BUSY: begin
          if (!mul_busy && !div_busy) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // commit only once the output register can take the result
          if (out_free) begin
            tick_q      <= tick_d;
            hit_q       <= hit_d;
            req_q       <= req_d;
            present_q   <= present_d;
            armed_q     <= armed_d;
            window_q    <= window_d;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // beat payload and result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q    <= kind_i;
      count_q   <= echo_count_i;
      timeout_q <= echo_timeout_i;
    end
    if (state_q == ST_DONE && out_free) begin
      present_o_q <= present_d;
      armed_o_q   <= armed_d;
      window_o_q  <= window_d;
      arr_o_q     <= arr_d;
      dep_o_q     <= dep_d;
      fire_o_q    <= fire_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign present_now_o    = present_o_q;
  assign armed_now_o      = armed_o_q;
  assign echo_in_window_o = window_o_q;
  assign arrived_o        = arr_o_q;
  assign departed_o       = dep_o_q;
  assign fire_action_o    = fire_o_q;
endmodule

/* tb/sv/tb_ultrasonic_presence_arming.sv */
// Self-checking testbench for the ultrasonic presence arming block.
module tb_ultrasonic_presence_arming;
  timeunit 1ns;
  timeprecision 1ps;

  import usp_pkg::*;

  // Block clock rate; sets the echo-count to centimetre scale
  localparam int unsigned ClkHz = 16_000_000;
  // Half the speed of sound in cm/s (out and back)
  localparam longint unsigned SoundCm = 17150;
  // Furthest distance a non-timeout echo can report at this clock rate
  localparam int MaxCm = int'((64'd65534 * SoundCm) / ClkHz);
  localparam int HitCeil  = 511;
  localparam int HitFloor = -512;
  localparam logic [1:0] KindSpare = 2'd3;
  localparam logic [CfgIdxW-1:0] CfgSpareLo = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSpareHi = 3'd7;
  localparam int unsigned RandomItems  = 1250;
  // Margin after the last result before a write
  localparam int unsigned SettleCycles = 20;

  typedef struct packed {
    logic present;
    logic armed;
    logic in_window;
    logic arrived;
    logic departed;
    logic fire;
  } presence_result_t;

  // Predicts each result from its input beat and holds the expected results in order.
  class presence_scoreboard;
    logic [15:0] period_r = AbsencePeriodRst;
    logic [7:0]  base_r   = HitBaseRst;
    logic [9:0]  near_r   = NearLimitRst;
    logic [9:0]  far_r    = FarLimitRst;
    logic [15:0] ticks = '0;
    int          hits = 0;
    logic [7:0]  need = '0;
    logic        present = 1'b0;
    logic        armed = 1'b0;
    logic        in_window = 1'b0;
    presence_result_t due[$];
    int unsigned errors = 0;
    int unsigned checked = 0;
    int unsigned arrivals = 0;
    int unsigned departures = 0;
    int unsigned fires = 0;

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
      case (idx)
        CfgAbsencePeriod: period_r = data;
        CfgHitBase:       base_r   = data[7:0];
        CfgNearLimit:     near_r   = data[9:0];
        CfgFarLimit:      far_r    = data[9:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [1:0] kind, logic [15:0] count, logic tout, logic [7:0] pot);
      presence_result_t r;
      longint unsigned span_cm;
      int old;
      r = '0;
      case (kind)
        KindEcho: begin
          need = 8'((int'(base_r) * int'(pot)) / 255);
          if (tout || count == 16'hFFFF) begin
            in_window = 1'b0;
            hits = 0;
          end else begin
            span_cm = count;
            span_cm = (span_cm * SoundCm) / ClkHz;
            if (span_cm < far_r && span_cm > near_r) begin
              in_window = 1'b1;
              if (!present) begin
                old = hits;
                if (hits < HitCeil) hits++;
                if (old >= int'(need)) begin
                  armed = 1'b1;
                  present = 1'b1;
                  ticks = '0;
                  r.arrived = 1'b1;
                end
              end
            end else begin
              in_window = 1'b0;
              hits = 0;
            end
          end
        end
        KindTick: begin
          ticks = ticks + 16'd1;
          if (ticks >= period_r) begin
            if (present) begin
              old = hits;
              if (hits > HitFloor) hits--;
              if (old * 100 < int'(need)) begin
                armed = 1'b0;
                present = 1'b0;
                r.departed = 1'b1;
              end
            end
            ticks = '0;
          end
        end
        KindMic: r.fire = armed;
        default: ;
      endcase
      r.present   = present;
      r.armed     = armed;
      r.in_window = in_window;
      arrivals   += r.arrived;
      departures += r.departed;
      fires      += r.fire;
      due.push_back(r);
    endfunction

    function void compare_flag(string name, logic want, logic got);
      if (want !== got) begin
        $display("%0t ns: %s mismatch, expected %b, actual %b", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(presence_result_t got);
      presence_result_t want;
      if (due.size() == 0) begin
        $display("%0t ns: result beat with nothing outstanding, actual %b", $time, got);
        errors++;
        return;
      end
      want = due.pop_front();
      compare_flag("present_now", want.present, got.present);
      compare_flag("armed_now", want.armed, got.armed);
      compare_flag("echo_in_window", want.in_window, got.in_window);
      compare_flag("arrived", want.arrived, got.arrived);
      compare_flag("departed", want.departed, got.departed);
      compare_flag("fire_action", want.fire, got.fire);
      checked++;
    endfunction

    function int unsigned pending();
      return due.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i = KindEcho;
  logic [15:0] echo_count_i = '0;
  logic        echo_timeout_i = 1'b0;
  logic [7:0]  pot_level_i = '0;

  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic present_now_o, armed_now_o, echo_in_window_o;
  logic arrived_o, departed_o, fire_action_o;

  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = CfgAbsencePeriod;
  logic [15:0]        cfg_data_i = '0;

  presence_scoreboard sb;
  int unsigned items_sent = 0;
  bit calm = 1'b0;   // phases with no idling on either side

  ultrasonic_presence_arming #(.CLK_HZ(ClkHz)) dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .kind_i, .echo_count_i, .echo_timeout_i, .pot_level_i,
    .out_valid_o, .out_ready_i, .present_now_o, .armed_now_o, .echo_in_window_o,
    .arrived_o, .departed_o, .fire_action_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // Observe all three channels at the edge; values read here are pre-edge.
  // Input beat is noted before the result check, though a result never
  // lands on the edge its own item is taken.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if (in_valid_i && in_ready_o)
        sb.note_item(kind_i, echo_count_i, echo_timeout_i, pot_level_i);
      if (out_valid_o && out_ready_i)
        sb.check_result({present_now_o, armed_now_o, echo_in_window_o,
                         arrived_o, departed_o, fire_action_o});
    end
  end

  // Mostly no gap, some short, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99, 0);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // Result-side back-pressure
  initial begin
    int unsigned stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = pick_gap();
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(6, 1)) @(posedge clk_i);
    end
  end

  // Smallest echo count that reads back as exactly cm centimetres
  function automatic logic [15:0] count_for_cm(int unsigned cm);
    longint unsigned c;
    c = cm;
    c = (c * ClkHz + SoundCm - 1) / SoundCm;
    return c[15:0];
  endfunction

  // Valid is left high after the beat so back-to-back items need no
  // second assignment in the same step; settle() drops it.
  task automatic send_item(input logic [1:0] kind, input logic [15:0] count,
                           input logic tout, input logic [7:0] pot);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    echo_count_i   <= count;
    echo_timeout_i <= tout;
    pot_level_i    <= pot;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    if (kind != KindSpare) items_sent++;
  endtask

  task automatic send_tick();
    send_item(KindTick, 16'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic send_mic();
    send_item(KindMic, 16'($urandom), 1'($urandom), 8'($urandom));
  endtask

  task automatic send_hit(input int lo, input int hi, input logic [7:0] pot);
    send_item(KindEcho, count_for_cm($urandom_range(hi, lo)), 1'b0, pot);
  endtask

  // Timeout flag, saturated counter, or echo right on the near limit (else zero echo)
  task automatic send_miss(input logic [7:0] pot);
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 33) send_item(KindEcho, 16'($urandom), 1'b1, pot);
    else if (r < 50) send_item(KindEcho, 16'hFFFF, 1'($urandom), pot);
    else if (int'(sb.near_r) <= MaxCm) send_item(KindEcho, count_for_cm(sb.near_r), 1'b0, pot);
    else send_item(KindEcho, 16'd0, 1'b0, pot);
  endtask

  // Drop valid, drain every expected result, then give the block time to go quiet.
  // The first edge lets the monitor note a beat taken on the edge we return on.
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // Unused upper data bits carry junk to show they are dropped
  task automatic program_regs(input logic [15:0] period, input logic [7:0] base,
                              input logic [9:0] near_cm, input logic [9:0] far_cm);
    write_reg(CfgAbsencePeriod, period);
    write_reg(CfgHitBase, {8'($urandom), base});
    write_reg(CfgNearLimit, {6'($urandom), near_cm});
    write_reg(CfgFarLimit, {6'($urandom), far_cm});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_regs();
    logic [15:0] per;
    logic [7:0]  base;
    logic [9:0]  near_cm, far_cm;
    int          f;
    case ($urandom_range(9, 0))
      0: per = 16'd0;
      1: per = 16'hFFFF;
      2: per = 16'($urandom);
      default: per = 16'($urandom_range(6, 1));
    endcase
    case ($urandom_range(9, 0))
      0: base = 8'd0;
      1: base = 8'hFF;
      default: base = 8'($urandom);
    endcase
    case ($urandom_range(9, 0))
      0: near_cm = 10'd0;
      1: near_cm = 10'h3FF;
      2: near_cm = 10'($urandom);
      default: near_cm = 10'($urandom_range(50, 0));
    endcase
    case ($urandom_range(9, 0))
      0: far_cm = 10'd0;
      1: far_cm = 10'h3FF;
      2: far_cm = 10'($urandom);
      default: begin
        f = int'(near_cm) + int'($urandom_range(40, 2));
        far_cm = (f > 1023) ? 10'h3FF : 10'(f);
      end
    endcase
    if ($urandom_range(4, 0) == 0)
      write_reg(3'($urandom_range(CfgSpareHi, CfgSpareLo)), 16'($urandom));
    program_regs(per, base, near_cm, far_cm);
  endtask

  // Unstructured beats across all kinds and full field ranges
  task automatic noise_run();
    int unsigned r;
    logic [1:0]  kind;
    repeat ($urandom_range(40, 20)) begin
      r = $urandom_range(19, 0);
      if (r == 0) kind = KindSpare;
      else begin
        case (r % 3)
          0: kind = KindEcho;
          1: kind = KindTick;
          default: kind = KindMic;
        endcase
      end
      send_item(kind, ($urandom_range(19, 0) == 0) ? 16'hFFFF : 16'($urandom),
                1'($urandom), 8'($urandom));
    end
  endtask

  // Arrival, armed triggers, then a capped run of ticks for the absence check to let go.
  // Pot is kept low enough that the hit requirement stays reachable.
  task automatic presence_run();
    int lo, hi, lim, need, per, nticks;
    int unsigned r;
    logic [7:0] pot;
    lo = int'(sb.near_r) + 1;
    hi = int'(sb.far_r) - 1;
    if (hi > MaxCm) hi = MaxCm;
    if (lo > hi) begin
      noise_run();
      return;
    end
    if (sb.base_r == 0) pot = 8'($urandom);
    else begin
      lim = 5100 / int'(sb.base_r);
      if (lim > 255) lim = 255;
      pot = 8'($urandom_range(lim, 0));
    end
    need = (int'(sb.base_r) * int'(pot)) / 255;
    repeat (need + 1 + int'($urandom_range(2, 0))) begin
      r = $urandom_range(99, 0);
      if (r < 8) send_mic();
      else if (r < 12) send_miss(pot);
      send_hit(lo, hi, pot);
    end
    repeat ($urandom_range(3, 1)) send_mic();
    per = (sb.period_r == 0) ? 1 : int'(sb.period_r);
    nticks = (need + 3) * per + int'($urandom_range(4, 0));
    if (nticks > 240) nticks = 240;
    repeat (nticks) begin
      r = $urandom_range(99, 0);
      if (r < 4) send_hit(lo, hi, pot);
      else if (r < 7) send_miss(pot);
      else if (r < 11) send_mic();
      send_tick();
    end
    send_mic();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: trigger while disarmed, both timeout forms, zero echo,
    // the unused kind with every bit set
    send_mic();
    send_item(KindEcho, 16'($urandom), 1'b1, 8'hFF);
    send_item(KindEcho, 16'hFFFF, 1'b0, 8'h00);
    send_item(KindEcho, 16'h0000, 1'b0, 8'h80);
    send_item(KindSpare, 16'hFFFF, 1'b1, 8'hFF);
    settle();

    // Writes past the last register must leave everything alone
    write_reg(CfgSpareLo, 16'hFFFF);
    write_reg(CfgSpareHi, 16'hFFFF);
    cfg_valid_i <= 1'b0;

    // Widest window, zero requirement, zero period: every tick ends a period
    program_regs(16'd0, 8'hFF, 10'd0, 10'h3FF);
    send_item(KindEcho, count_for_cm(10), 1'b0, 8'h00);   // arrives at once
    send_item(KindEcho, count_for_cm(20), 1'b0, 8'h00);   // hit while present
    send_mic();                                           // fires
    send_tick();                                          // count 1 -> 0
    send_tick();                                          // 0 -> -1, check still false
    send_tick();                                          // negative count departs
    send_mic();
    send_item(KindEcho, 16'hFFFE, 1'b0, 8'hFF);           // longest echo, full pot
    send_item(KindEcho, 16'h0000, 1'b0, 8'hFF);           // zero distance misses near=0
    settle();

    // Period cut below the running tick count ends it on the next tick
    program_regs(16'd10, 8'd2, 10'd0, 10'h3FF);
    repeat (3) send_item(KindEcho, count_for_cm(30), 1'b0, 8'hFF);
    send_item(KindEcho, 16'($urandom), 1'b1, 8'hFF);      // timeout clears the hits
    repeat (4) send_tick();
    settle();
    program_regs(16'd2, 8'd2, 10'd0, 10'h3FF);
    send_tick();                                          // departs

    // Random phases: new settings each time, mostly presence sequences
    items_sent = 0;
    while (items_sent < RandomItems) begin
      settle();
      calm = ($urandom_range(3, 0) == 0);
      random_regs();
      repeat ($urandom_range(3, 1)) begin
        if ($urandom_range(9, 0) < 7) presence_run();
        else noise_run();
      end
    end
    settle();

    $display("Checked %0d result beats over %0d random items after the directed set.",
             sb.checked, items_sent);
    $display("Seen: %0d arrivals, %0d departures, %0d trigger fires.",
             sb.arrivals, sb.departures, sb.fires);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hang guard: 20 ms is several times the slowest legal run
  initial begin
    #(20_000_000);
    $display("Verification failed");
    $finish;
  end

endmodule

/* ultrasonic_presence_arming.f */
rtl/usp_pkg.sv
rtl/usp_req_mul.sv
rtl/usp_dist_div.sv
rtl/ultrasonic_presence_arming.sv
tb/sv/tb_ultrasonic_presence_arming.sv
